FILE: sv/pdsn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the path dot-segment normaliser.
// Used by pdsn_seq and path_dot_segment_normalizer; no dependencies.
package pdsn_pkg;

  localparam int MAX_PATH_UNITS = 4096;
  localparam int IDX_W          = $clog2(MAX_PATH_UNITS);
  localparam int LEN_W          = $clog2(MAX_PATH_UNITS + 1);
  localparam int UNIT_W         = 16;

  localparam logic [UNIT_W-1:0] SEP_UNIT = 16'h005C;
  localparam logic [UNIT_W-1:0] DOT_UNIT = 16'h002E;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_POP  = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  // One input item
  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              has;
    logic              last;
  } item_t;

  // One result item
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  wi;
    logic [UNIT_W-1:0] wu;
    logic [LEN_W-1:0]  len;
    status_t           status;
    logic              done;
  } res_t;

endpackage

FILE: sv/pdsn_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pdsn_ram #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/pdsn_seq.sv
`timescale 1ns / 1ps
// Sequencer of the path normaliser: length, error and tail registers, the
// dot-segment check, the backward scan and tail reload. Uses pdsn_pkg, pdsn_ram.
module pdsn_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pdsn_pkg::item_t in_item,
  input  logic           out_free,
  output logic           emit,
  output pdsn_pkg::res_t res
);

  typedef enum logic [2:0] {
    S_IDLE, S_UNIT, S_TRIM, S_SCAN_RD, S_SCAN_CK, S_RLD, S_POST, S_DONE
  } state_t;

  state_t                            state, state_next;
  pdsn_pkg::item_t                   item, item_next;
  logic [pdsn_pkg::LEN_W-1:0]        len, len_next;
  pdsn_pkg::status_t                 err, err_next;
  logic [pdsn_pkg::UNIT_W-1:0]       t1, t1_next, t2, t2_next, t3, t3_next;
  logic                              ctx_last, ctx_last_next;
  logic [pdsn_pkg::IDX_W-1:0]        scan_i, scan_i_next;
  logic [1:0]                        rld_k, rld_k_next;
  logic                              res_we, res_we_next;
  logic [pdsn_pkg::IDX_W-1:0]        res_wi, res_wi_next;
  logic [pdsn_pkg::UNIT_W-1:0]       res_wu, res_wu_next;

  logic                              push_req, push_ok, go_last;
  logic [pdsn_pkg::UNIT_W-1:0]       push_val;
  logic [pdsn_pkg::IDX_W-1:0]        mem_raddr;
  logic [pdsn_pkg::UNIT_W-1:0]       mem_rdata;
  logic [pdsn_pkg::LEN_W-1:0]        rld_addr, scan_start;

  assign rld_addr   = len - pdsn_pkg::LEN_W'(1) - pdsn_pkg::LEN_W'(rld_k);
  assign scan_start = len - pdsn_pkg::LEN_W'(4);
  assign push_ok    = push_req && (len < pdsn_pkg::LEN_W'(pdsn_pkg::MAX_PATH_UNITS));

  pdsn_ram #(
    .AW (pdsn_pkg::IDX_W),
    .DW (pdsn_pkg::UNIT_W)
  ) u_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (len[pdsn_pkg::IDX_W-1:0]),
    .wdata (push_val),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result of the current item as it stands
  always_comb begin
    res.we     = res_we;
    res.wi     = res_wi;
    res.wu     = res_wu;
    res.len    = len;
    res.status = err;
    res.done   = item.last;
  end

  // Next-state logic
  always_comb begin
    state_next    = state;
    item_next     = item;
    len_next      = len;
    err_next      = err;
    t1_next       = t1;
    t2_next       = t2;
    t3_next       = t3;
    ctx_last_next = ctx_last;
    scan_i_next   = scan_i;
    rld_k_next    = rld_k;
    res_we_next   = res_we;
    res_wi_next   = res_wi;
    res_wu_next   = res_wu;
    push_req      = 1'b0;
    push_val      = pdsn_pkg::SEP_UNIT;
    go_last       = 1'b0;
    emit          = 1'b0;
    in_ready      = 1'b0;
    mem_raddr     = scan_i;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next   = in_item;
          res_we_next = 1'b0;
          res_wi_next = '0;
          res_wu_next = '0;
          state_next  = S_UNIT;
        end
      end

      // Take the unit: zero check, plain push, or start a dot check on a separator
      S_UNIT: begin
        go_last = 1'b1;
        if (err == pdsn_pkg::ST_OK && item.has) begin
          if (item.unit == '0) begin
            err_next = pdsn_pkg::ST_ZERO;
          end else if (item.unit != pdsn_pkg::SEP_UNIT) begin
            push_req = 1'b1;
            push_val = item.unit;
          end else begin
            go_last       = 1'b0;
            ctx_last_next = 1'b0;
            state_next    = S_TRIM;
          end
        end
      end

      // Resolve a trailing "\." or "\.." from the tail registers
      S_TRIM: begin
        if (len == '0 || t1 != pdsn_pkg::DOT_UNIT || len == pdsn_pkg::LEN_W'(1)) begin
          state_next = S_POST;
        end else if (t2 == pdsn_pkg::SEP_UNIT) begin
          len_next   = len - pdsn_pkg::LEN_W'(2);
          rld_k_next = '0;
          state_next = S_RLD;
        end else if (len == pdsn_pkg::LEN_W'(2) || t2 != pdsn_pkg::DOT_UNIT ||
                     t3 != pdsn_pkg::SEP_UNIT) begin
          state_next = S_POST;
        end else if (len == pdsn_pkg::LEN_W'(3)) begin
          err_next   = pdsn_pkg::ST_POP;
          state_next = S_POST;
        end else begin
          scan_i_next = scan_start[pdsn_pkg::IDX_W-1:0];
          state_next  = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        state_next = S_SCAN_CK;
      end

      // Look for the separator that opens the component being popped
      S_SCAN_CK: begin
        if (mem_rdata == pdsn_pkg::SEP_UNIT) begin
          len_next   = pdsn_pkg::LEN_W'(scan_i);
          rld_k_next = '0;
          state_next = S_RLD;
        end else if (scan_i == '0) begin
          err_next   = pdsn_pkg::ST_POP;
          state_next = S_POST;
        end else begin
          scan_i_next = scan_i - pdsn_pkg::IDX_W'(1);
          state_next  = S_SCAN_RD;
        end
      end

      // Refill the tail registers from the store after the length shrank
      S_RLD: begin
        mem_raddr  = rld_addr[pdsn_pkg::IDX_W-1:0];
        rld_k_next = rld_k + 2'd1;
        case (rld_k)
          2'd1:    t1_next = mem_rdata;
          2'd2:    t2_next = mem_rdata;
          2'd3: begin
            t3_next    = mem_rdata;
            state_next = S_POST;
          end
          default: ;
        endcase
      end

      // After a separator's dot check, push the separator unless one ends the path; after the end-of-path check, finish
      S_POST: begin
        if (!ctx_last) begin
          go_last = 1'b1;
          if (err == pdsn_pkg::ST_OK && (len == '0 || t1 != pdsn_pkg::SEP_UNIT)) begin
            push_req = 1'b1;
          end
        end else begin
          state_next = S_DONE;
        end
      end

      // Hand the result over, close the path on its last item, take the next item
      S_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          in_ready = 1'b1;
          if (item.last) begin
            len_next = '0;
            err_next = pdsn_pkg::ST_OK;
          end
          if (in_valid) begin
            item_next   = in_item;
            res_we_next = 1'b0;
            res_wi_next = '0;
            res_wu_next = '0;
            state_next  = S_UNIT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Append one unit, or flag overflow when the store is full
    if (push_req) begin
      if (push_ok) begin
        t3_next     = t2;
        t2_next     = t1;
        t1_next     = push_val;
        len_next    = len + pdsn_pkg::LEN_W'(1);
        res_we_next = 1'b1;
        res_wi_next = len[pdsn_pkg::IDX_W-1:0];
        res_wu_next = push_val;
      end else begin
        err_next = pdsn_pkg::ST_OVF;
      end
    end

    // Unit phase over: run the end-of-path dot check or finish
    if (go_last) begin
      if (item.last && err_next == pdsn_pkg::ST_OK) begin
        ctx_last_next = 1'b1;
        state_next    = S_TRIM;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  // State and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      err   <= pdsn_pkg::ST_OK;
    end else begin
      state <= state_next;
      len   <= len_next;
      err   <= err_next;
    end
    item     <= item_next;
    t1       <= t1_next;
    t2       <= t2_next;
    t3       <= t3_next;
    ctx_last <= ctx_last_next;
    scan_i   <= scan_i_next;
    rld_k    <= rld_k_next;
    res_we   <= res_we_next;
    res_wi   <= res_wi_next;
    res_wu   <= res_wu_next;
  end

endmodule

FILE: sv/path_dot_segment_normalizer.sv
`timescale 1ns / 1ps
// Top level of the path dot-segment normaliser: stream ports and output
// register around the sequencer. Uses pdsn_pkg and pdsn_seq.
//
//  Channel   Dir  Payload
//  s_axis    in   tdata: code_unit; tuser: has_unit; tlast: last
//  m_axis    out  tdata: write_index, write_unit, new_length, status;
//                 tuser: write_enable; tlast: done_res
//
// A separator adds a dot check, a reload of the tail after a "\." removal and,
// for a "\.." pop, a backward scan of the store plus the reload; a last item
// repeats the dot check. The single read port of the path store sets the scan
// rate. rst is synchronous, returns the sequencer to idle and clears length,
// error and the output valid. A new item is taken while the previous result
// waits in the output register.
module path_dot_segment_normalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tuser,   // [0] has_unit
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [11:0] write_index, [27:12] write_unit,
                                      // [40:28] new_length, [42:41] status, rest 0
  output logic        m_axis_tuser,   // [0] write_enable
  output logic        m_axis_tlast
);

  pdsn_pkg::item_t in_item;
  pdsn_pkg::res_t  res, out_res;
  logic            emit, out_free;

  assign in_item.unit = s_axis_tdata;
  assign in_item.has  = s_axis_tuser;
  assign in_item.last = s_axis_tlast;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  pdsn_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .emit     (emit),
    .res      (res)
  );

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (emit) begin
      out_res <= res;
    end
  end

  // Pack the result item
  assign m_axis_tdata = {5'b0, out_res.status, out_res.len, out_res.wu, out_res.wi};
  assign m_axis_tuser = out_res.we;
  assign m_axis_tlast = out_res.done;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for path_dot_segment_normalizer: directed dot-segment
// and error cases, then random paths under bursty input and stalls.
// Depends on pdsn_pkg and the normaliser RTL only.
module tb;

  localparam int RANDOM_ITEMS = 1600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] code_unit
  logic        s_axis_tuser = 1'b0; // [0] has_unit
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [11:0] write_index, [27:12] write_unit,
                                    // [40:28] new_length, [42:41] status
  logic        m_axis_tuser;        // [0] write_enable
  logic        m_axis_tlast;

  path_dot_segment_normalizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the normalised path
  logic [15:0]        path_mem [pdsn_pkg::MAX_PATH_UNITS];
  int                 path_len = 0;
  pdsn_pkg::status_t  path_err = pdsn_pkg::ST_OK;

  pdsn_pkg::res_t pending_steps[$];
  int   items_sent = 0;
  int   steps_seen = 0;
  int   mismatches = 0;
  int   burst_left = 0;

  // Resolve a trailing "\." or "\.."; returns 0 when the pop has no separator to land on
  function automatic bit resolve_dots();
    int n;
    int i;
    n = path_len;
    if (n == 0 || path_mem[n-1] != pdsn_pkg::DOT_UNIT || n == 1) return 1'b1;
    if (path_mem[n-2] == pdsn_pkg::SEP_UNIT) begin
      path_len = n - 2;
      return 1'b1;
    end
    if (n == 2 || path_mem[n-2] != pdsn_pkg::DOT_UNIT || path_mem[n-3] != pdsn_pkg::SEP_UNIT)
      return 1'b1;
    if (n == 3) return 1'b0;
    // scan back for the separator in front of the parent component
    i = n - 3;
    while (i > 0) begin
      i--;
      if (path_mem[i] == pdsn_pkg::SEP_UNIT) begin
        path_len = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void append_unit(input logic [15:0] u, inout pdsn_pkg::res_t r);
    if (path_len >= pdsn_pkg::MAX_PATH_UNITS) begin
      path_err = pdsn_pkg::ST_OVF;
    end else begin
      path_mem[path_len] = u;
      r.we = 1'b1;
      r.wi = path_len[pdsn_pkg::IDX_W-1:0];
      r.wu = u;
      path_len++;
    end
  endfunction

  // Advance the shadow path by one item and return the step it should report
  function automatic pdsn_pkg::res_t normalise_step(input logic [15:0] unit, input logic has,
                                                    input logic last);
    pdsn_pkg::res_t r;
    r = '0;
    if (path_err == pdsn_pkg::ST_OK && has) begin
      if (unit == 16'h0000) path_err = pdsn_pkg::ST_ZERO;
      else if (unit != pdsn_pkg::SEP_UNIT) append_unit(unit, r);
      else if (!resolve_dots()) path_err = pdsn_pkg::ST_POP;
      else if (path_len == 0 || path_mem[path_len-1] != pdsn_pkg::SEP_UNIT)
        append_unit(pdsn_pkg::SEP_UNIT, r);
    end
    if (path_err == pdsn_pkg::ST_OK && last && !resolve_dots()) path_err = pdsn_pkg::ST_POP;
    r.len    = path_len[pdsn_pkg::LEN_W-1:0];
    r.status = path_err;
    r.done   = last;
    if (last) begin
      path_len = 0;
      path_err = pdsn_pkg::ST_OK;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: step %0d %s expected %0h got %0h", $time, steps_seen, field, want, got);
  endtask

  // Send one item: bursts of random length separated by random gaps
  task automatic send_item(input logic [15:0] unit, input logic has, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= unit;
    s_axis_tuser  <= has;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_steps = {pending_steps, normalise_step(unit, has, last)};
    items_sent++;
  endtask

  // Send a path written as text; optionally mark the final character last
  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_item({8'h00, s[i]}, 1'b1, close && (i == s.len() - 1));
  endtask

  task automatic send_repeat(input logic [15:0] unit, input int count);
    repeat (count) send_item(unit, 1'b1, 1'b0);
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin : check_steps
    pdsn_pkg::res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_steps.size() == 0) begin
        flag_mismatch("unexpected result", 0, m_axis_tdata[42:41]);
      end else begin
        want = pending_steps.pop_front();
        if (m_axis_tuser != want.we) flag_mismatch("write_enable", want.we, m_axis_tuser);
        if (m_axis_tdata[11:0] != want.wi)
          flag_mismatch("write_index", want.wi, m_axis_tdata[11:0]);
        if (m_axis_tdata[27:12] != want.wu)
          flag_mismatch("write_unit", want.wu, m_axis_tdata[27:12]);
        if (m_axis_tdata[40:28] != want.len)
          flag_mismatch("new_length", want.len, m_axis_tdata[40:28]);
        if (m_axis_tdata[42:41] != want.status)
          flag_mismatch("status", want.status, m_axis_tdata[42:41]);
        if (m_axis_tlast != want.done) flag_mismatch("done", want.done, m_axis_tlast);
        if (m_axis_tdata[47:43] != '0) flag_mismatch("padding", 0, m_axis_tdata[47:43]);
      end
      steps_seen++;
    end
  end

  // Receiver stalls: modes of random length, from always ready to rarely ready
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        m_axis_tready <= (rx_phase % 5 != 0);
      end
    endcase
  end

  // Field extremes and every bit of the code unit
  task automatic test_extreme_units();
    send_item(16'h005C, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);
    send_item(16'h0001, 1'b1, 1'b0);
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h5555, 1'b1, 1'b0);
    send_item(16'hAAAA, 1'b1, 1'b0);
    send_item(16'h7FFF, 1'b1, 1'b1);
  endtask

  task automatic test_separator_runs();
    send_text("\\\\\\a\\\\b\\", 1'b1);
  endtask

  task automatic test_single_dot();
    send_text("\\a\\.\\b\\.", 1'b1);
  endtask

  // Parent pops, including a leading ".." component
  task automatic test_parent_pop();
    send_text("\\a\\b\\..\\c\\..", 1'b1);
    send_text("..\\b\\..\\..", 1'b1);
  endtask

  task automatic test_pop_above_root();
    send_text("\\..", 1'b1);
    send_text("a\\..", 1'b1);
    send_text("\\..\\x", 1'b1);
  endtask

  // Zero unit sets a sticky error until the path ends
  task automatic test_zero_unit();
    send_text("\\a", 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_text("b\\", 1'b0);
    send_item(16'h0000, 1'b0, 1'b1);
  endtask

  // Bare items mid-path, bare end marker and an empty path
  task automatic test_bare_items();
    send_text("\\a", 1'b0);
    send_item(16'hFFFF, 1'b0, 1'b0);
    send_text("\\.", 1'b0);
    send_item(16'h0000, 1'b0, 1'b1);
    send_item(16'h0000, 1'b0, 1'b1);
  endtask

  // Pop a long component: long scan back to its separator
  task automatic test_long_scan();
    send_text("\\a\\", 1'b0);
    send_repeat(16'h0062, 300);
    send_text("\\..\\c", 1'b1);
  endtask

  function automatic logic [15:0] pick_name_unit();
    logic [15:0] u;
    case ($urandom_range(0, 9)) inside
      [0:3]: u = 16'(16'h0061 + $urandom_range(0, 2));
      [4:5]: u = pdsn_pkg::DOT_UNIT;
      6: begin
        u = 16'($urandom_range(1, 65535));
        if (u == pdsn_pkg::SEP_UNIT) u = 16'hFFFF;
      end
      default: u = 16'h0078;
    endcase
    return u;
  endfunction

  // Mostly well-formed paths of names, "." and ".."; some noise paths
  task automatic test_random_paths();
    logic [15:0] units[$];
    int          nseg;
    int          kind;
    while (items_sent < RANDOM_ITEMS) begin
      units.delete();
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) != 0) units = {units, pdsn_pkg::SEP_UNIT};
        nseg = $urandom_range(1, 8);
        for (int s = 0; s < nseg; s++) begin
          kind = $urandom_range(0, 5);
          if (kind == 0) begin
            units = {units, pdsn_pkg::DOT_UNIT};
          end else if (kind == 1) begin
            units = {units, pdsn_pkg::DOT_UNIT, pdsn_pkg::DOT_UNIT};
          end else begin
            repeat ($urandom_range(1, 5)) units = {units, pick_name_unit()};
          end
          if (s < nseg - 1 || $urandom_range(0, 3) == 0)
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
              units = {units, pdsn_pkg::SEP_UNIT};
        end
      end else begin
        // noise: any unit value, zero and separators included
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 7)) inside
            0:       units = {units, 16'h0000};
            [1:2]:   units = {units, pdsn_pkg::SEP_UNIT};
            3:       units = {units, pdsn_pkg::DOT_UNIT};
            default: units = {units, 16'($urandom_range(0, 65535))};
          endcase
        end
      end
      kind = $urandom_range(0, 1);
      foreach (units[k]) begin
        if ($urandom_range(0, 19) == 0) send_item(16'($urandom_range(0, 65535)), 1'b0, 1'b0);
        send_item(units[k], 1'b1, kind == 1 && k == units.size() - 1);
      end
      if (kind == 0) send_item(16'($urandom_range(0, 65535)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_units();
    test_separator_runs();
    test_single_dot();
    test_parent_pop();
    test_pop_above_root();
    test_zero_unit();
    test_bare_items();
    test_long_scan();
    test_random_paths();
    // drop valid and let every predicted step arrive
    s_axis_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
sv/pdsn_pkg.sv
sv/pdsn_ram.sv
sv/pdsn_seq.sv
sv/path_dot_segment_normalizer.sv
tb/tb.sv
